[rtl/ils_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store: operation codes,
// status codes, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Request and response field widths.
   localparam int OP_W       = 4;
   localparam int POS_W      = 5;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_GET_AT       = 4'd0,
      OP_GET_FIRST    = 4'd1,
      OP_GET_LAST     = 4'd2,
      OP_ADD_AT       = 4'd3,
      OP_ADD_FIRST    = 4'd4,
      OP_ADD_LAST     = 4'd5,
      OP_REMOVE_AT    = 4'd6,
      OP_REMOVE_FIRST = 4'd7,
      OP_REMOVE_LAST  = 4'd8,
      OP_SET_AT       = 4'd9,
      OP_CONTAINS     = 4'd10
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // What a request turns into once its checks have been done.
   typedef enum logic [2:0] {
      KIND_FAIL,
      KIND_READ,
      KIND_WRITE,
      KIND_INSERT,
      KIND_REMOVE,
      KIND_SEARCH
   } kind_type;

   // What the datapath does with the data of a memory read in the cycle after it.
   typedef enum logic [1:0] {
      RDM_PLAIN,
      RDM_UP,
      RDM_DOWN,
      RDM_CMP
   } rd_mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_RD_ISSUE,
      S_RD_CAP,
      S_WR_PUT,
      S_SHIFT_UP,
      S_INS_LAST,
      S_INS_PUT,
      S_REM_FIRST,
      S_REM_CAP,
      S_REM_SHIFT,
      S_REM_DRAIN,
      S_SCAN,
      S_SCAN_END,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        load;
      logic        rd;
      rd_mode_type rd_mode;
      logic        addr_inc;
      logic        addr_dec;
      logic        addr_last;
      logic        put;
      logic        capture;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     addr_eq_pos;
      logic     addr_eq_last;
      logic     addr_eq_cnt;
      logic     cnt_zero;
      logic     out_free;
   } sts_type;

endpackage

[rtl/ils_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer for the indexed list store. Steps the datapath through reads,
// shifts, searches and the result hand-off for one request at a time.
// ----------------------------------------------------------------------------
module ils_ctrl
   import ils_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.kind)
               KIND_READ:   state_in = S_RD_ISSUE;
               KIND_WRITE:  state_in = S_WR_PUT;
               KIND_INSERT: state_in = sts.addr_eq_cnt ? S_INS_PUT : S_SHIFT_UP;
               KIND_REMOVE: state_in = S_REM_FIRST;
               KIND_SEARCH: state_in = sts.cnt_zero ? S_FINISH : S_SCAN;
               default:     state_in = S_FINISH;
            endcase
         end
         S_RD_ISSUE:  state_in = S_RD_CAP;
         S_RD_CAP:    state_in = S_FINISH;
         S_WR_PUT:    state_in = S_FINISH;
         S_SHIFT_UP: begin
            if (sts.addr_eq_pos) begin
               state_in = S_INS_LAST;
            end
         end
         S_INS_LAST:  state_in = S_INS_PUT;
         S_INS_PUT:   state_in = S_FINISH;
         S_REM_FIRST: state_in = S_REM_CAP;
         S_REM_CAP:   state_in = sts.addr_eq_cnt ? S_REM_DRAIN : S_REM_SHIFT;
         S_REM_SHIFT: begin
            if (sts.addr_eq_last) begin
               state_in = S_REM_DRAIN;
            end
         end
         S_REM_DRAIN: state_in = S_FINISH;
         S_SCAN: begin
            if (sts.addr_eq_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END:  state_in = S_FINISH;
         S_FINISH: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_DISPATCH: begin
            cmd.addr_last = (sts.kind == KIND_INSERT) && !sts.addr_eq_cnt;
         end
         S_RD_ISSUE: begin
            cmd.rd      = 1'b1;
            cmd.rd_mode = RDM_PLAIN;
         end
         S_RD_CAP:    cmd.capture = 1'b1;
         S_WR_PUT:    cmd.put = 1'b1;
         S_SHIFT_UP: begin
            cmd.rd       = 1'b1;
            cmd.rd_mode  = RDM_UP;
            cmd.addr_dec = !sts.addr_eq_pos;
         end
         S_INS_LAST: begin
            cmd.rd = 1'b0;
         end
         S_INS_PUT: begin
            cmd.put     = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         S_REM_FIRST: begin
            cmd.rd       = 1'b1;
            cmd.rd_mode  = RDM_PLAIN;
            cmd.addr_inc = 1'b1;
         end
         S_REM_CAP:   cmd.capture = 1'b1;
         S_REM_SHIFT: begin
            cmd.rd       = 1'b1;
            cmd.rd_mode  = RDM_DOWN;
            cmd.addr_inc = 1'b1;
         end
         S_REM_DRAIN: cmd.cnt_dec = 1'b1;
         S_SCAN: begin
            cmd.rd       = 1'b1;
            cmd.rd_mode  = RDM_CMP;
            cmd.addr_inc = 1'b1;
         end
         S_SCAN_END: begin
            cmd.rd = 1'b0;
         end
         S_FINISH:    cmd.finish = sts.out_free;
         default:     cmd = '0;
      endcase
   end

endmodule

[rtl/ils_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_dpath
// Datapath of the indexed list store: element memory, entry count, walking
// address, request checks, shift and compare pipeline, and the result register.
// ----------------------------------------------------------------------------
module ils_dpath
   import ils_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int ELEMENT_WIDTH = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       req_op,
   input  logic [POS_W-1:0]      req_pos,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic [ELEMENT_WIDTH-1:0] element_mem [DEPTH];

   logic [CW-1:0]            count_ff,     count_in;
   logic [CW-1:0]            addr_ff,      addr_in;
   logic [CW-1:0]            pos_ff,       pos_in;
   logic [ELEMENT_WIDTH-1:0] val_ff,       val_in;
   kind_type                 kind_ff,      kind_in;
   logic [STATUS_W-1:0]      status_ff,    status_in;
   logic [ELEMENT_WIDTH-1:0] res_value_ff, res_value_in;
   logic                     found_ff,     found_in;
   logic [ELEMENT_WIDTH-1:0] rd_data_ff;
   logic                     pend_wr_ff,   pend_wr_in;
   logic [AW-1:0]            pend_addr_ff, pend_addr_in;
   logic                     pend_cmp_ff,  pend_cmp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff,  rsp_data_in;

   // Request checks against the current count.
   kind_type                 chk_kind;
   status_type               chk_status;
   logic [PW-1:0]            chk_pos;
   logic [PW-1:0]            pos_x;
   logic [PW-1:0]            cnt_x;
   logic                     cnt_zero;
   logic                     cnt_full;
   logic [ELEMENT_WIDTH-1:0] req_val_w;
   logic [CW-1:0]            count_last;

   assign pos_x      = PW'(req_pos);
   assign cnt_x      = PW'(count_ff);
   assign cnt_zero   = (count_ff == '0);
   assign cnt_full   = (count_ff == CW'(DEPTH));
   assign req_val_w  = (ELEMENT_WIDTH)'(req_value);
   assign count_last = count_ff - CW'(1);

   always_comb begin
      chk_kind   = KIND_FAIL;
      chk_status = ST_RANGE;
      chk_pos    = '0;
      case (op_type'(req_op))
         OP_GET_AT, OP_SET_AT: begin
            chk_pos = pos_x;
            if (pos_x < cnt_x) begin
               chk_status = ST_OK;
               chk_kind   = (op_type'(req_op) == OP_SET_AT) ? KIND_WRITE : KIND_READ;
            end
         end
         OP_GET_FIRST, OP_GET_LAST: begin
            chk_pos = (op_type'(req_op) == OP_GET_FIRST) ? '0 : cnt_x - PW'(1);
            if (!cnt_zero) begin
               chk_status = ST_OK;
               chk_kind   = KIND_READ;
            end
         end
         OP_ADD_AT, OP_ADD_FIRST, OP_ADD_LAST: begin
            if (op_type'(req_op) == OP_ADD_FIRST) begin
               chk_pos = '0;
            end else if (op_type'(req_op) == OP_ADD_LAST) begin
               chk_pos = cnt_x;
            end else begin
               chk_pos = pos_x;
            end
            if (chk_pos > cnt_x) begin
               chk_status = ST_RANGE;
            end else if (cnt_full) begin
               chk_status = ST_FULL;
            end else begin
               chk_status = ST_OK;
               chk_kind   = KIND_INSERT;
            end
         end
         OP_REMOVE_AT, OP_REMOVE_FIRST, OP_REMOVE_LAST: begin
            if (op_type'(req_op) == OP_REMOVE_FIRST) begin
               chk_pos = '0;
            end else if (op_type'(req_op) == OP_REMOVE_LAST) begin
               chk_pos = cnt_x - PW'(1);
            end else begin
               chk_pos = pos_x;
            end
            if (!cnt_zero && (chk_pos < cnt_x)) begin
               chk_status = ST_OK;
               chk_kind   = KIND_REMOVE;
            end
         end
         OP_CONTAINS: begin
            chk_status = ST_OK;
            chk_kind   = KIND_SEARCH;
         end
         default: begin
            chk_status = ST_RANGE;
            chk_kind   = KIND_FAIL;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      addr_in      = addr_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      res_value_in = res_value_ff;
      found_in     = found_ff;
      pend_wr_in   = cmd.rd && ((cmd.rd_mode == RDM_UP) || (cmd.rd_mode == RDM_DOWN));
      pend_cmp_in  = cmd.rd && (cmd.rd_mode == RDM_CMP);
      pend_addr_in = (cmd.rd_mode == RDM_UP) ? addr_ff[AW-1:0] + AW'(1)
                                             : addr_ff[AW-1:0] - AW'(1);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         kind_in      = chk_kind;
         status_in    = chk_status;
         // Only failing requests carry out-of-range positions and never use them, so the narrowing is safe.
         pos_in       = CW'(chk_pos);
         addr_in      = CW'(chk_pos);
         val_in       = req_val_w;
         found_in     = 1'b0;
         res_value_in = ((chk_kind == KIND_WRITE) || (chk_kind == KIND_INSERT))
                        ? req_val_w : '0;
      end

      if (cmd.addr_last) begin
         addr_in = count_last;
      end else if (cmd.addr_inc) begin
         addr_in = addr_ff + CW'(1);
      end else if (cmd.addr_dec) begin
         addr_in = addr_ff - CW'(1);
      end

      if (cmd.capture) begin
         res_value_in = rd_data_ff;
      end

      if (pend_cmp_ff && (rd_data_ff == val_ff)) begin
         found_in     = 1'b1;
         res_value_in = val_ff;
      end

      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {COUNT_W'(count_ff), status_ff, found_ff, VALUE_W'(res_value_ff)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         kind_ff      <= KIND_FAIL;
         pend_wr_ff   <= 1'b0;
         pend_cmp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         kind_ff      <= kind_in;
         pend_wr_ff   <= pend_wr_in;
         pend_cmp_ff  <= pend_cmp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      status_ff    <= status_in;
      res_value_ff <= res_value_in;
      found_ff     <= found_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Element memory: one write port, one registered read port. A shift writes
   // back the word read on the previous cycle one place up or down.
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         element_mem[addr_ff[AW-1:0]] <= val_ff;
      end else if (pend_wr_ff) begin
         element_mem[pend_addr_ff] <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= element_mem[addr_ff[AW-1:0]];
      end
   end

   assign sts.kind         = kind_ff;
   assign sts.addr_eq_pos  = (addr_ff == pos_ff);
   assign sts.addr_eq_last = (addr_ff == count_last);
   assign sts.addr_eq_cnt  = (addr_ff == count_ff);
   assign sts.cnt_zero     = cnt_zero;
   assign sts.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/indexed_list_store.sv]
`timescale 1ns / 1ps
// Inserts other than at the end, removes and searches walk the element memory, which has
// one write port and one read port, one entry per cycle. One request is in work at a
// time; the store is ready for the next in the cycle after the response is registered,
// and a response still waiting holds the next one back. Reset empties the list, drops a
// waiting response and returns the sequencer to idle; it does not clear the memory.
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of up to DEPTH elements kept packed at the bottom of a memory,
// with reads, inserts, removes, overwrites and searches by position or value.
// ----------------------------------------------------------------------------
module indexed_list_store
   import ils_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int ELEMENT_WIDTH = 32
)
(
   input  logic                  clock,
   input  logic                  reset,

   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] operation, [8:4] position, [40:9] item_value, [47:41] zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,

   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] read_value, [32] found, [34:33] status, [39:35] entry_count
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Request fields. The zero fill above item_value is not looked at.
   logic [OP_W-1:0]    req_op;
   logic [POS_W-1:0]   req_pos;
   logic [VALUE_W-1:0] req_value;

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_pos   = req_tdata[OP_W+POS_W-1:OP_W];
   assign req_value = req_tdata[OP_W+POS_W+VALUE_W-1:OP_W+POS_W];

   // The controller and the datapath talk only through these two bundles.
   cmd_type cmd;
   sts_type sts;

   // The sequencer decides, one state per cycle, which memory access the
   // datapath makes. Inserts walk down from the last entry, removes walk up
   // from the removed position, and searches sweep the whole list.
   ils_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath checks each request as it is accepted, so a failing
   // request touches neither the memory nor the count. It also holds the
   // response register, which frees the request side while a response waits.
   ils_dpath #(
      .DEPTH         (DEPTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_op),
      .req_pos    (req_pos),
      .req_value  (req_value),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
